FILE: sv/dlts_pkg.sv
`default_nettype none
package dlts_pkg;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_DISPATCH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NONE_DUE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_TICK = 2'd1,
        CELL_INS  = 2'd2,
        CELL_DEL  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic        valid;
        logic        due;
        logic [15:0] handle;
        logic [31:0] delta;
        logic [31:0] period;
        logic [31:0] id;
    } t_entry;

    // Control broadcast to every cell; the position travels beside it.
    typedef struct packed {
        t_cell_op    op;
        t_entry      new_entry;
        logic        adj_en;
        logic [31:0] adj_delta;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] task_handle;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [31:0] target_id;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_id;
        logic [15:0] run_handle;
        logic        run_valid;
        logic [31:0] rearm_id;
        logic        head_due;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/delta_list_task_scheduler.sv
`default_nettype none
// Delta-list timer queue. A command beat is taken at a rising edge where start
// is high and busy is low; its mode selects tick, add, delete or dispatch.
// Each command produces exactly one result beat on o_result, marked by o_done
// for a single cycle. The receiver has no way to hold results off, and none
// is needed: the result sits in its own register and busy stays high until
// that register has been loaded.
// Entries live in a row of MAX_TASKS cells, packed at the front and ordered
// by due time, each keeping its delay relative to its predecessor. Inserting
// or removing an entry shifts every cell from its position onward by one
// place, all together. Finding the place is a walk with one cell per cycle
// through a shared scan pointer and a 33-bit running-sum adder.
// Tick, refused add, delete of id zero, dispatch of a one-shot head and
// dispatch with nothing due go straight to the finish state. An add or a
// delete first scans the cells from the head; a dispatch of a periodic head
// re-inserts it through the same add scan.
// Synchronous reset empties all cells and restarts id numbering, so the first id given out is one.
module delta_list_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire dlts_pkg::t_item i_item,
    output logic                 busy,
    output logic                 o_done,
    output dlts_pkg::t_result    o_result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN_ADD = 5'b00010,
        S_SCAN_DEL = 5'b00100,
        S_FINISH   = 5'b01000,
        S_SPARE    = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic [32:0]           r_sum, n_sum;
    logic [31:0]           r_last_id, n_last_id;
    logic [15:0]           r_new_handle, n_new_handle;
    logic [31:0]           r_delay, n_delay;
    logic [31:0]           r_period, n_period;
    logic [31:0]           r_target, n_target;
    logic                  r_rearm, n_rearm;
    dlts_pkg::t_result     r_work, n_work;
    dlts_pkg::t_result     r_res;
    dlts_pkg::t_result     w_res;
    logic                  r_done;

    dlts_pkg::t_entry      w_cell [MAX_TASKS];
    dlts_pkg::t_entry      w_scan;
    dlts_pkg::t_cell_ctl   w_ctl;
    logic [IW-1:0]         w_pos;
    logic [32:0]           w_sum_next;
    logic [31:0]           w_fresh;
    logic                  w_accept;
    logic [31:0]           w_own;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            dlts_pkg::t_entry w_left, w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_cell[gi-1];
            end
            if (gi == MAX_TASKS - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_cell[gi+1];
            end
            dlts_cell #(.IDX(gi), .IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_cell[gi])
            );
        end
    endgenerate

    assign w_accept   = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign w_scan     = w_cell[r_idx];
    assign w_sum_next = r_sum + {1'b0, w_scan.delta};
    assign w_fresh    = (r_last_id == 32'hFFFF_FFFF) ? 32'd1 : r_last_id + 32'd1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_sum        = r_sum;
        n_last_id    = r_last_id;
        n_new_handle = r_new_handle;
        n_delay      = r_delay;
        n_period     = r_period;
        n_target     = r_target;
        n_rearm      = r_rearm;
        n_work       = r_work;
        w_ctl        = '0;
        w_ctl.op     = dlts_pkg::CELL_HOLD;
        w_pos        = '0;
        w_own        = r_delay - r_sum[31:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_work       = '0;
                    n_idx        = '0;
                    n_sum        = '0;
                    n_rearm      = 1'b0;
                    n_new_handle = i_item.task_handle;
                    n_delay      = i_item.start_delay;
                    n_period     = i_item.repeat_period;
                    n_target     = i_item.target_id;
                    n_state      = S_FINISH;
                    unique case (dlts_pkg::t_mode'(i_item.mode))
                        dlts_pkg::MODE_TICK: begin
                            if (w_cell[0].valid && !w_cell[0].due) begin
                                w_ctl.op = dlts_pkg::CELL_TICK;
                            end
                        end
                        dlts_pkg::MODE_ADD: begin
                            if (w_cell[MAX_TASKS-1].valid) begin
                                n_work.status = dlts_pkg::ST_FULL;
                            end else begin
                                n_state = S_SCAN_ADD;
                            end
                        end
                        dlts_pkg::MODE_DELETE: begin
                            if (i_item.target_id == 32'd0) begin
                                n_work.status = dlts_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN_DEL;
                            end
                        end
                        dlts_pkg::MODE_DISPATCH: begin
                            if (w_cell[0].valid && w_cell[0].due) begin
                                n_work.result_id  = w_cell[0].id;
                                n_work.run_handle = w_cell[0].handle;
                                n_work.run_valid  = 1'b1;
                                w_ctl.op          = dlts_pkg::CELL_DEL;
                                if (w_cell[0].period != 32'd0) begin
                                    n_new_handle = w_cell[0].handle;
                                    n_delay      = w_cell[0].period;
                                    n_period     = w_cell[0].period;
                                    n_rearm      = 1'b1;
                                    n_state      = S_SCAN_ADD;
                                end
                            end else begin
                                n_work.status = dlts_pkg::ST_NONE_DUE;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN_ADD: begin
                // Insert before the first entry whose running sum passes the delay,
                // or into the first free cell.
                if (!w_scan.valid || (w_sum_next > {1'b0, r_delay})) begin
                    w_ctl.op                  = dlts_pkg::CELL_INS;
                    w_pos                     = r_idx;
                    w_ctl.adj_en              = w_scan.valid;
                    w_ctl.adj_delta           = w_sum_next[31:0] - r_delay;
                    w_ctl.new_entry.valid     = 1'b1;
                    w_ctl.new_entry.due       = (w_own == 32'd0);
                    w_ctl.new_entry.handle    = r_new_handle;
                    w_ctl.new_entry.delta     = w_own;
                    w_ctl.new_entry.period    = r_period;
                    w_ctl.new_entry.id        = w_fresh;
                    n_last_id                 = w_fresh;
                    if (r_rearm) begin
                        n_work.rearm_id = w_fresh;
                    end else begin
                        n_work.result_id = w_fresh;
                    end
                    n_state = S_FINISH;
                end else begin
                    n_sum = w_sum_next;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN_DEL: begin
                if (w_scan.valid && w_scan.id == r_target) begin
                    w_ctl.op = dlts_pkg::CELL_DEL;
                    w_pos    = r_idx;
                    n_state  = S_FINISH;
                end else if (!w_scan.valid || r_idx == IW'(MAX_TASKS - 1)) begin
                    n_work.status = dlts_pkg::ST_NOT_FOUND;
                    n_state       = S_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The cells have settled by the finish cycle, so the head flag is current.
    always_comb begin
        w_res          = r_work;
        w_res.head_due = w_cell[0].valid && w_cell[0].due;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last_id <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last_id <= n_last_id;
            r_done    <= (r_state == S_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_sum        <= n_sum;
        r_new_handle <= n_new_handle;
        r_delay      <= n_delay;
        r_period     <= n_period;
        r_target     <= n_target;
        r_rearm      <= n_rearm;
        r_work       <= n_work;
        if (r_state == S_FINISH) begin
            r_res <= w_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

FILE: sv/dlts_cell.sv
`default_nettype none
// One table slot. It keeps its entry, takes one from a neighbor or the new entry, or counts down at the head.
module dlts_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire dlts_pkg::t_cell_ctl i_ctl,
    input  wire  [IW-1:0]            i_pos,
    input  wire dlts_pkg::t_entry    i_left,
    input  wire dlts_pkg::t_entry    i_right,
    output dlts_pkg::t_entry         o_entry
);

    dlts_pkg::t_entry r_entry;
    dlts_pkg::t_entry n_entry;
    logic [31:0]      w_sum;
    logic [31:0]      w_dec;
    logic [IW:0]      w_pos_next;

    assign w_sum      = i_right.delta + r_entry.delta;
    assign w_dec      = (r_entry.delta == 32'd0) ? 32'd0 : r_entry.delta - 32'd1;
    assign w_pos_next = {1'b0, i_pos} + {{IW{1'b0}}, 1'b1};

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            dlts_pkg::CELL_TICK: begin
                if (IDX == 0) begin
                    n_entry.delta = w_dec;
                    n_entry.due   = (w_dec == 32'd0);
                end
            end
            dlts_pkg::CELL_INS: begin
                if (IW'(IDX) == i_pos) begin
                    n_entry = i_ctl.new_entry;
                end else if ((IW+1)'(IDX) == w_pos_next) begin
                    n_entry = i_left;
                    if (i_ctl.adj_en) begin
                        n_entry.delta = i_ctl.adj_delta;
                    end
                end else if (IW'(IDX) > i_pos) begin
                    n_entry = i_left;
                end
            end
            dlts_pkg::CELL_DEL: begin
                if (IW'(IDX) >= i_pos) begin
                    n_entry = i_right;
                    if (IW'(IDX) == i_pos && i_right.valid) begin
                        n_entry.delta = w_sum;
                        if (w_sum != 32'd0) begin
                            n_entry.due = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire
